// File: rtl/core/trpp_pkg.sv
// ----------------------------------------------------------------------------
// Turn-rate position predictor package
// Shared widths, fixed-point constants, pipeline stage map and the CORDIC
// arctangent table.
// ----------------------------------------------------------------------------
package trpp_pkg;

  // Number of CORDIC rotations, one pipeline stage each (8 to 32).
  localparam int CORDIC_STEPS = 20;

  // Port field widths.
  localparam int THR_W = 16;
  localparam int POS_W = 32;
  localparam int SPD_W = 24;
  localparam int YAW_W = 20;
  localparam int HOR_W = 16;

  // Internal widths.
  localparam int YABS_W = 20;  // magnitude of the yaw rate
  localparam int SDY_W  = 31;  // straight-line offset
  localparam int ANG_W  = 36;  // yaw rate times horizon, Q26 rad
  localparam int RED_W  = 42;  // biased angle during range reduction
  localparam int RED_N  = 8;   // conditional subtractions of 2*pi multiples
  localparam int CW     = 36;  // CORDIC datapath
  localparam int PROD_W = 60;  // speed times sine or one minus cosine
  localparam int DIV_W  = 44;  // dividend and quotient
  localparam int OFF_W  = 47;  // signed offset and position sum

  // Fixed-point angle constants in Q30.
  localparam logic [RED_W-1:0] TWO_PI_Q30  = 42'd6746518852;
  localparam logic [RED_W-1:0] PI_Q30      = 42'd3373259426;
  localparam logic [RED_W-1:0] HALF_PI_Q30 = 42'd1686629713;
  // 128 turns, keeps the biased angle positive for every input.
  localparam logic [RED_W-1:0] RED_BIAS    = 42'd863554413056;
  localparam logic signed [CW-1:0] GAIN_Q30 = 36'sd652032874;
  localparam logic signed [CW-1:0] ONE_Q30  = 36'sd1073741824;

  localparam logic [THR_W-1:0] THR_RESET = 16'd7;

  // Pipeline stage map.
  localparam int ST_IN   = 0;
  localparam int ST_PRE  = ST_IN + 1;
  localparam int ST_RED0 = ST_PRE + 1;
  localparam int ST_F1   = ST_RED0 + RED_N;
  localparam int ST_F2   = ST_F1 + 1;
  localparam int ST_CRD0 = ST_F2 + 1;
  localparam int ST_NRM  = ST_CRD0 + CORDIC_STEPS;
  localparam int ST_MUL  = ST_NRM + 1;
  localparam int ST_ABS  = ST_MUL + 1;
  localparam int ST_DVD  = ST_ABS + 1;
  localparam int ST_DIV0 = ST_DVD + 1;
  localparam int ST_OFF  = ST_DIV0 + DIV_W;
  localparam int ST_LAST = ST_OFF;

  // Per-item values that ride along the whole pipeline.
  typedef struct packed {
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic signed [SPD_W-1:0] v;
    logic                    wneg;
    logic [YABS_W-1:0]       wabs;
    logic                    straight;
    logic signed [SDY_W-1:0] sdy;
  } side_t;

  // Arctangent of 2^-i in Q30.
  function automatic logic [31:0] atan_q30(input int unsigned i);
    logic [31:0] a;
    case (i)
      0:  a = 32'h3243F6A8;
      1:  a = 32'h1DAC6705;
      2:  a = 32'h0FADBAFC;
      3:  a = 32'h07F56EA6;
      4:  a = 32'h03FEAB76;
      5:  a = 32'h01FFD55B;
      6:  a = 32'h00FFFAAA;
      7:  a = 32'h007FFF55;
      8:  a = 32'h003FFFEA;
      9:  a = 32'h001FFFFD;
      10: a = 32'h000FFFFF;
      11: a = 32'h0007FFFF;
      12: a = 32'h0003FFFF;
      13: a = 32'h0001FFFF;
      14: a = 32'h0000FFFF;
      15: a = 32'h00007FFF;
      16: a = 32'h00003FFF;
      17: a = 32'h00001FFF;
      18: a = 32'h00000FFF;
      19: a = 32'h000007FF;
      20: a = 32'h000003FF;
      21: a = 32'h000001FF;
      22: a = 32'h000000FF;
      23: a = 32'h0000007F;
      24: a = 32'h0000003F;
      25: a = 32'h0000001F;
      26: a = 32'h0000000F;
      27: a = 32'h00000008;
      28: a = 32'h00000004;
      29: a = 32'h00000002;
      30: a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

// File: rtl/core/turn_rate_position_predictor_top.sv
// ----------------------------------------------------------------------------
// Turn-rate position predictor
// One pipeline stage per CORDIC rotation and one stage per quotient bit of
// the two parallel dividers set the depth of the pipeline.
// Throughput: one item per cycle; the whole pipeline holds while a result
// waits at the output. Reset clears all valid bits and sets the threshold to 7.
// ----------------------------------------------------------------------------
module turn_rate_position_predictor_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [15:0]               cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [31:0]        pos_x_i,
  input  logic signed [31:0]        pos_y_i,
  input  logic signed [23:0]        speed_i,
  input  logic signed [19:0]        yaw_rate_i,
  input  logic [15:0]               horizon_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [31:0]        future_x_o,
  output logic signed [31:0]        future_y_o,
  output logic                      saturated_o
);

  localparam int STEPS  = trpp_pkg::CORDIC_STEPS;
  localparam int LAST   = trpp_pkg::ST_LAST;
  localparam int ANG_W  = trpp_pkg::ANG_W;
  localparam int RED_W  = trpp_pkg::RED_W;
  localparam int RED_N  = trpp_pkg::RED_N;
  localparam int CW     = trpp_pkg::CW;
  localparam int PROD_W = trpp_pkg::PROD_W;
  localparam int DIV_W  = trpp_pkg::DIV_W;
  localparam int OFF_W  = trpp_pkg::OFF_W;
  localparam int YABS_W = trpp_pkg::YABS_W;
  localparam int SDY_W  = trpp_pkg::SDY_W;
  localparam logic signed [CW-1:0] PI_S   = CW'(trpp_pkg::PI_Q30);
  localparam logic signed [CW-1:0] HALF_S = CW'(trpp_pkg::HALF_PI_Q30);
  localparam logic signed [CW-1:0] TWO_S  = CW'(trpp_pkg::TWO_PI_Q30);

  // Global advance: every stage moves when the output register can take an item.
  logic adv;
  logic out_valid_q;
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  // Threshold register.
  logic [15:0] thr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= trpp_pkg::THR_RESET;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // Valid bits and side values travel together down the pipeline.
  logic            valid_q [LAST+1];
  trpp_pkg::side_t side_q  [LAST+1];

  // Input stage: straight-line offset, yaw magnitude and angle product.
  logic [YABS_W-1:0]       wabs_d;
  logic signed [40:0]      spd_x, hor_x, vt, vt_rnd;
  logic signed [ANG_W:0]   yaw_x, hor_a, ang_full;
  trpp_pkg::side_t         side_d;
  logic signed [ANG_W-1:0] ang_q;

  always_comb begin
    wabs_d   = yaw_rate_i[19] ? YABS_W'(-yaw_rate_i) : YABS_W'(yaw_rate_i);
    spd_x    = 41'(speed_i);
    hor_x    = signed'(41'(horizon_i));
    vt       = spd_x * hor_x;
    vt_rnd   = vt + 41'sd512;
    yaw_x    = (ANG_W+1)'(yaw_rate_i);
    hor_a    = signed'((ANG_W+1)'(horizon_i));
    ang_full = yaw_x * hor_a;
    side_d.px       = pos_x_i;
    side_d.py       = pos_y_i;
    side_d.v        = speed_i;
    side_d.wneg     = yaw_rate_i[19];
    side_d.wabs     = wabs_d;
    side_d.straight = (yaw_rate_i == '0) || (wabs_d < YABS_W'(thr_q));
    side_d.sdy      = vt_rnd[SDY_W+9:10];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else if (adv) begin
      valid_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= side_d;
      ang_q     <= ang_full[ANG_W-1:0];
    end
  end

  // Shift the valid bits and side values along.
  for (genvar k = 1; k <= LAST; k++) begin : g_side
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (adv) begin
        valid_q[k] <= valid_q[k-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // Bias stage: scale the angle to Q30 and add whole turns so it is positive.
  logic [RED_W-1:0]      red_q [RED_N+1];
  logic signed [RED_W:0] pre_ext, pre_sum;

  always_comb begin
    pre_ext = {{(RED_W+1-ANG_W-4){ang_q[ANG_W-1]}}, ang_q, 4'b0000};
    pre_sum = pre_ext + signed'({1'b0, trpp_pkg::RED_BIAS});
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      red_q[0] <= pre_sum[RED_W-1:0];
    end
  end

  // Range reduction: subtract 2*pi times a falling power of two, one per stage.
  for (genvar k = 0; k < RED_N; k++) begin : g_red
    localparam logic [RED_W-1:0] SUB = trpp_pkg::TWO_PI_Q30 << (RED_N - 1 - k);
    always_ff @(posedge clk_i) begin
      if (adv) begin
        red_q[k+1] <= (red_q[k] >= SUB) ? red_q[k] - SUB : red_q[k];
      end
    end
  end

  // Map the angle into (-pi, pi].
  logic signed [CW-1:0] m_s, r_q;
  assign m_s = signed'(red_q[RED_N][CW-1:0]);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r_q <= (m_s > PI_S) ? m_s - TWO_S : m_s;
    end
  end

  // Fold into [-pi/2, pi/2]; the fold negates sine and cosine.
  logic signed [CW-1:0] cx_q [STEPS+1];
  logic signed [CW-1:0] cy_q [STEPS+1];
  logic signed [CW-1:0] cz_q [STEPS+1];
  logic                 cn_q [STEPS+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cx_q[0] <= trpp_pkg::GAIN_Q30;
      cy_q[0] <= '0;
      if (r_q > HALF_S) begin
        cz_q[0] <= r_q - PI_S;
        cn_q[0] <= 1'b1;
      end else if (r_q < -HALF_S) begin
        cz_q[0] <= r_q + PI_S;
        cn_q[0] <= 1'b1;
      end else begin
        cz_q[0] <= r_q;
        cn_q[0] <= 1'b0;
      end
    end
  end

  // CORDIC rotations, one per stage.
  for (genvar i = 0; i < STEPS; i++) begin : g_cordic
    localparam logic signed [CW-1:0] ATAN_I = CW'(trpp_pkg::atan_q30(i));
    always_ff @(posedge clk_i) begin
      if (adv) begin
        cn_q[i+1] <= cn_q[i];
        if (!cz_q[i][CW-1]) begin
          cx_q[i+1] <= cx_q[i] - (cy_q[i] >>> i);
          cy_q[i+1] <= cy_q[i] + (cx_q[i] >>> i);
          cz_q[i+1] <= cz_q[i] - ATAN_I;
        end else begin
          cx_q[i+1] <= cx_q[i] + (cy_q[i] >>> i);
          cy_q[i+1] <= cy_q[i] - (cx_q[i] >>> i);
          cz_q[i+1] <= cz_q[i] + ATAN_I;
        end
      end
    end
  end

  // Sine and one minus cosine with the fold applied.
  logic signed [CW-1:0] sin_q, omc_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sin_q <= cn_q[STEPS] ? -cy_q[STEPS] : cy_q[STEPS];
      omc_q <= cn_q[STEPS] ? trpp_pkg::ONE_Q30 + cx_q[STEPS]
                           : trpp_pkg::ONE_Q30 - cx_q[STEPS];
    end
  end

  // Products with the speed.
  logic signed [PROD_W-1:0] v_ext, prody_q, prodx_q;
  assign v_ext = PROD_W'(side_q[trpp_pkg::ST_NRM].v);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prody_q <= v_ext * PROD_W'(sin_q);
      prodx_q <= v_ext * PROD_W'(omc_q);
    end
  end

  // Quotient signs and numerator magnitudes; x uses the negated product.
  logic [PROD_W-1:0] magx_q, magy_q;
  logic              absnx_q, absny_q;
  logic              wneg_m;
  assign wneg_m = side_q[trpp_pkg::ST_MUL].wneg;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      magy_q  <= prody_q[PROD_W-1] ? PROD_W'(-prody_q) : PROD_W'(prody_q);
      magx_q  <= prodx_q[PROD_W-1] ? PROD_W'(-prodx_q) : PROD_W'(prodx_q);
      absny_q <= prody_q[PROD_W-1] ^ wneg_m;
      absnx_q <= (!prodx_q[PROD_W-1] && (prodx_q != '0)) ^ wneg_m;
    end
  end

  // Rounding bias and removal of the 2^14 factor of the divisor.
  logic [DIV_W-1:0]  nx_q [DIV_W+1];
  logic [DIV_W-1:0]  ny_q [DIV_W+1];
  logic [YABS_W-1:0] rx_q [DIV_W+1];
  logic [YABS_W-1:0] ry_q [DIV_W+1];
  logic              sx_q [DIV_W+1];
  logic              sy_q [DIV_W+1];
  logic [PROD_W:0]   half_d, sumx_b, sumy_b;

  always_comb begin
    half_d = (PROD_W+1)'({side_q[trpp_pkg::ST_ABS].wabs, 13'b0});
    sumx_b = (PROD_W+1)'(magx_q) + half_d;
    sumy_b = (PROD_W+1)'(magy_q) + half_d;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      nx_q[0] <= sumx_b[DIV_W+13:14];
      ny_q[0] <= sumy_b[DIV_W+13:14];
      rx_q[0] <= '0;
      ry_q[0] <= '0;
      sx_q[0] <= absnx_q;
      sy_q[0] <= absny_q;
    end
  end

  // Restoring dividers by the yaw magnitude, one quotient bit per stage.
  for (genvar j = 0; j < DIV_W; j++) begin : g_div
    logic [YABS_W:0] tx, ty, dv;
    always_comb begin
      dv = {1'b0, side_q[trpp_pkg::ST_DVD + j].wabs};
      tx = {rx_q[j], nx_q[j][DIV_W-1]};
      ty = {ry_q[j], ny_q[j][DIV_W-1]};
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        sx_q[j+1] <= sx_q[j];
        sy_q[j+1] <= sy_q[j];
        if (tx >= dv) begin
          rx_q[j+1] <= YABS_W'(tx - dv);
          nx_q[j+1] <= {nx_q[j][DIV_W-2:0], 1'b1};
        end else begin
          rx_q[j+1] <= tx[YABS_W-1:0];
          nx_q[j+1] <= {nx_q[j][DIV_W-2:0], 1'b0};
        end
        if (ty >= dv) begin
          ry_q[j+1] <= YABS_W'(ty - dv);
          ny_q[j+1] <= {ny_q[j][DIV_W-2:0], 1'b1};
        end else begin
          ry_q[j+1] <= ty[YABS_W-1:0];
          ny_q[j+1] <= {ny_q[j][DIV_W-2:0], 1'b0};
        end
      end
    end
  end

  // Signed offsets; the straight case uses the precomputed y offset.
  logic signed [OFF_W-1:0] qx_s, qy_s, dx_q, dy_q;
  logic                    str_d;
  always_comb begin
    qx_s  = signed'(OFF_W'(nx_q[DIV_W]));
    qy_s  = signed'(OFF_W'(ny_q[DIV_W]));
    str_d = side_q[trpp_pkg::ST_OFF - 1].straight;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (str_d) begin
        dx_q <= '0;
        dy_q <= OFF_W'(side_q[trpp_pkg::ST_OFF - 1].sdy);
      end else begin
        dx_q <= sx_q[DIV_W] ? -qx_s : qx_s;
        dy_q <= sy_q[DIV_W] ? -qy_s : qy_s;
      end
    end
  end

  // Position sum and saturation into the output register.
  logic signed [OFF_W-1:0] fx, fy;
  logic                    hi_x, lo_x, hi_y, lo_y;
  logic signed [31:0]      fx_c, fy_c;

  always_comb begin
    fx   = OFF_W'(side_q[LAST].px) + dx_q;
    fy   = OFF_W'(side_q[LAST].py) + dy_q;
    hi_x = !fx[OFF_W-1] && (fx[OFF_W-2:31] != '0);
    lo_x = fx[OFF_W-1] && (fx[OFF_W-2:31] != '1);
    hi_y = !fy[OFF_W-1] && (fy[OFF_W-2:31] != '0);
    lo_y = fy[OFF_W-1] && (fy[OFF_W-2:31] != '1);
    fx_c = hi_x ? 32'sh7FFFFFFF : (lo_x ? 32'sh80000000 : fx[31:0]);
    fy_c = hi_y ? 32'sh7FFFFFFF : (lo_y ? 32'sh80000000 : fy[31:0]);
  end

  logic signed [31:0] fut_x_q, fut_y_q;
  logic               sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= valid_q[LAST];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fut_x_q <= fx_c;
      fut_y_q <= fy_c;
      sat_q   <= hi_x || lo_x || hi_y || lo_y;
    end
  end

  assign out_valid_o = out_valid_q;
  assign future_x_o  = fut_x_q;
  assign future_y_o  = fut_y_q;
  assign saturated_o = sat_q;

endmodule
